### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Types and constants of the escaped frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    localparam logic [7:0] FLAG_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_FLAG     = 8'h5E;
    localparam logic [7:0] ESC_ESC      = 8'h5D;
    localparam logic [7:0] CTRL_MAX     = 8'h20;

    localparam int          BODY_LEN    = 22;
    localparam int          IDX_W       = 5;
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_DONE  = IDX_W'(BODY_LEN + 1);

    localparam int          QUEUE_DEPTH = 4;

    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_CTRL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_ID = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_FLD  = 2'd3;

    localparam logic [7:0]  RST_HDR_ADDR = 8'hFF;
    localparam logic [7:0]  RST_HDR_CTRL = 8'h03;
    localparam logic [15:0] RST_PROTO_ID = 16'hA021;
    localparam logic [15:0] RST_LEN_FLD  = 16'h000D;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    localparam int OUT_W = 112;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] index;
    } t_op;

    typedef struct packed {
        logic [7:0]  hdr_addr;
        logic [7:0]  hdr_ctrl;
        logic [15:0] proto_id;
        logic [15:0] len_fld;
    } t_cfg;

    typedef struct packed {
        logic             in_frame;
        logic             esc;
        logic [IDX_W-1:0] index;
    } t_front_status;

endpackage

`default_nettype wire

### rtl/efd_front.sv
// ----------------------------------------------------------------------------
// efd_front
// Unstuffs received bytes, tracks framing and issues store and close ops.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_byte,
    output logic                        o_push,
    output efd_pkg::t_op                o_op,
    output efd_pkg::t_front_status      o_status
);

    logic                        r_in_frame, n_in_frame;
    logic                        r_esc, n_esc;
    logic [efd_pkg::IDX_W-1:0]   r_index, n_index;

    always_comb begin
        logic       store;
        logic       bad;
        logic [7:0] value;
        store      = 1'b0;
        bad        = 1'b0;
        value      = i_byte;
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_index    = r_index;
        o_push     = 1'b0;
        o_op.kind  = efd_pkg::OP_STORE;
        o_op.data  = value;
        o_op.index = r_index;
        if (i_accept) begin
            if (i_byte == efd_pkg::FLAG_BYTE) begin
                if (r_in_frame && r_index == efd_pkg::IDX_DONE) begin
                    o_push    = 1'b1;
                    o_op.kind = efd_pkg::OP_CLOSE;
                end
                n_in_frame = 1'b1;
                n_esc      = 1'b0;
                n_index    = efd_pkg::IDX_FIRST;
            end else if (!r_in_frame) begin
                n_esc   = 1'b0;
                n_index = efd_pkg::IDX_FIRST;
            end else if (i_byte == efd_pkg::ESC_BYTE) begin
                n_esc = 1'b1;
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_byte <= efd_pkg::CTRL_MAX) begin
                    store = 1'b1;
                end else if (i_byte == efd_pkg::ESC_FLAG) begin
                    store = 1'b1;
                    value = efd_pkg::FLAG_BYTE;
                end else if (i_byte == efd_pkg::ESC_ESC) begin
                    store = 1'b1;
                    value = efd_pkg::ESC_BYTE;
                end else begin
                    bad = 1'b1;
                end
            end else if (i_byte > efd_pkg::CTRL_MAX) begin
                store = 1'b1;
            end else begin
                bad = 1'b1;
            end

            if (store) begin
                if (r_index < efd_pkg::IDX_DONE) begin
                    o_push    = 1'b1;
                    o_op.data = value;
                    n_index   = r_index + 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end

            if (bad) begin
                n_in_frame = 1'b0;
                n_esc      = 1'b0;
                n_index    = efd_pkg::IDX_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_index    <= efd_pkg::IDX_FIRST;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_index    <= n_index;
        end
    end

    assign o_status.in_frame = r_in_frame;
    assign o_status.esc      = r_esc;
    assign o_status.index    = r_index;

endmodule

`default_nettype wire

### rtl/efd_queue.sv
// ----------------------------------------------------------------------------
// efd_queue
// Short FIFO of ops between the byte front end and the frame back end.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_queue #(
    parameter int DEPTH = efd_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire efd_pkg::t_op   i_op,
    output logic                o_full,
    output logic                o_valid,
    output efd_pkg::t_op        o_head,
    input  wire logic           i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    efd_pkg::t_op    r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/efd_back.sv
// ----------------------------------------------------------------------------
// efd_back
// Collects body bytes, runs header and checksum checks, drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire efd_pkg::t_cfg             i_cfg,
    input  wire logic                      i_valid,
    input  wire efd_pkg::t_op              i_op,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [efd_pkg::OUT_W-1:0]      o_data
);

    logic [7:0]  r_xor, r_sum;
    logic        r_hdr_ok, r_chk_ok;
    logic [7:0]  r_cmd, r_len_code;
    logic [31:0] r_lead;
    logic [63:0] r_payload;
    logic        r_out_valid;
    logic [efd_pkg::OUT_W-1:0] r_out_data;

    logic out_free, do_store, do_close;
    logic [7:0] b;
    logic [efd_pkg::IDX_W-1:0] idx;

    assign b        = i_op.data;
    assign idx      = i_op.index;
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && (i_op.kind == efd_pkg::OP_STORE || out_free);
    assign do_store = o_pop && i_op.kind == efd_pkg::OP_STORE;
    assign do_close = o_pop && i_op.kind == efd_pkg::OP_CLOSE;

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            if (idx == 5'd1) begin
                r_xor    <= b;
                r_sum    <= b;
                r_hdr_ok <= (b == i_cfg.hdr_addr);
            end else if (idx inside {[5'd2:5'd20]}) begin
                r_xor <= r_xor ^ b;
                r_sum <= r_sum + b;
            end
            case (idx)
                5'd2:  r_hdr_ok <= r_hdr_ok && (b == i_cfg.hdr_ctrl);
                5'd3:  r_hdr_ok <= r_hdr_ok && (b == i_cfg.proto_id[15:8]);
                5'd4:  r_hdr_ok <= r_hdr_ok && (b == i_cfg.proto_id[7:0]);
                5'd5:  r_hdr_ok <= r_hdr_ok && (b == i_cfg.len_fld[15:8]);
                5'd6:  r_hdr_ok <= r_hdr_ok && (b == i_cfg.len_fld[7:0]);
                5'd7:  r_cmd <= b;
                5'd12: r_len_code <= b;
                5'd21: r_chk_ok <= (r_xor == b);
                5'd22: r_chk_ok <= r_chk_ok && (r_sum == b);
                default: ;
            endcase
            if (idx inside {[5'd8:5'd11]}) begin
                r_lead <= {r_lead[23:0], b};
            end
            if (idx inside {[5'd13:5'd20]}) begin
                r_payload <= {r_payload[55:0], b};
            end
        end
        if (do_close) begin
            r_out_data <= {r_payload, r_len_code, r_lead, r_cmd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_close && r_hdr_ok && r_chk_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/escaped_frame_deframer.sv
// tvalid rises once the close op has passed through the op FIFO and set the registered output valid.
// Throughput: one byte per cycle; the front end is ready while the op FIFO has room.
// A stalled result holds a close op at the back end; the FIFO absorbs QUEUE_DEPTH ops meanwhile.
// Reset: synchronous, active low; clears framing state, FIFO and output valid,
// and loads the header registers with their defaults.
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Byte-stuffed serial frame receiver with header and checksum check.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module escaped_frame_deframer #(
    parameter int QUEUE_DEPTH = efd_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [efd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // rx_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // command[7:0], lead_word[39:8], length_code[47:40], payload[111:48]
    output logic [efd_pkg::OUT_W-1:0]          m_axis_tdata
);

    efd_pkg::t_cfg          r_cfg;
    efd_pkg::t_op           front_op, q_head;
    efd_pkg::t_front_status front_status;
    logic                   front_push, q_full, q_valid, q_pop, in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_addr <= efd_pkg::RST_HDR_ADDR;
            r_cfg.hdr_ctrl <= efd_pkg::RST_HDR_CTRL;
            r_cfg.proto_id <= efd_pkg::RST_PROTO_ID;
            r_cfg.len_fld  <= efd_pkg::RST_LEN_FLD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                efd_pkg::CFG_HDR_ADDR: r_cfg.hdr_addr <= i_cfg_data[7:0];
                efd_pkg::CFG_HDR_CTRL: r_cfg.hdr_ctrl <= i_cfg_data[7:0];
                efd_pkg::CFG_PROTO_ID: r_cfg.proto_id <= i_cfg_data;
                efd_pkg::CFG_LEN_FLD:  r_cfg.len_fld  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    efd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .o_push   (front_push),
        .o_op     (front_op),
        .o_status (front_status)
    );

    efd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    efd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_op    (q_head),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    `ASSERT_IMPLIES(a_idle_state, i_clk, i_rst_n, !front_status.in_frame,
        !front_status.esc && front_status.index == efd_pkg::IDX_FIRST,
        "front state not cleared outside a frame")
    `ASSERT_ALWAYS(a_index_range, i_clk, i_rst_n,
        front_status.index >= efd_pkg::IDX_FIRST && front_status.index <= efd_pkg::IDX_DONE,
        "body index out of range")
    `ASSERT_IMPLIES(a_result_source, i_clk, i_rst_n, $rose(m_axis_tvalid),
        $past(q_pop && q_head.kind == efd_pkg::OP_CLOSE),
        "result without a close transaction")

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for escaped_frame_deframer. A short table of raw bytes
// covers ignored bytes, escapes and aborts. Random byte-stuffed frames follow
// under five header settings, some with bad headers or checksums, wrong
// lengths or broken escapes. A predictor decodes each accepted byte and every
// decoded frame is compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF           = 5;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int DRAIN_CYCLES       = 4 * efd_pkg::QUEUE_DEPTH + 8;
    localparam int NUM_SETTINGS       = 5;
    localparam int BYTES_PER_SETTING  = 170;
    localparam int FRAMES_PER_SETTING = 4;
    localparam int HOLD_CYCLES        = 400;

    typedef enum logic {CHK_MODEL, CHK_NONE} t_chk;

    typedef struct packed {
        logic [7:0] data;
        t_chk       chk;
    } t_rx_item;

    typedef struct packed {
        logic [63:0] payload;
        logic [7:0]  length_code;
        logic [31:0] lead_word;
        logic [7:0]  command;
    } t_frame;

    localparam t_rx_item DIRECTED_ROWS [25] = '{
        '{8'h00, CHK_NONE}, '{8'hFF, CHK_NONE}, '{efd_pkg::ESC_BYTE, CHK_NONE},
        '{8'h41, CHK_NONE}, '{efd_pkg::FLAG_BYTE, CHK_NONE},
        '{efd_pkg::ESC_BYTE, CHK_NONE}, '{efd_pkg::ESC_BYTE, CHK_NONE},
        '{efd_pkg::ESC_FLAG, CHK_NONE}, '{efd_pkg::ESC_BYTE, CHK_NONE},
        '{efd_pkg::FLAG_BYTE, CHK_NONE},
        '{8'h21, CHK_MODEL}, '{8'h1F, CHK_NONE}, '{8'h80, CHK_NONE},
        '{efd_pkg::FLAG_BYTE, CHK_NONE}, '{efd_pkg::ESC_BYTE, CHK_NONE},
        '{8'h80, CHK_NONE},
        '{efd_pkg::FLAG_BYTE, CHK_MODEL}, '{efd_pkg::ESC_BYTE, CHK_MODEL},
        '{8'h00, CHK_MODEL}, '{efd_pkg::ESC_BYTE, CHK_MODEL},
        '{efd_pkg::CTRL_MAX, CHK_MODEL}, '{efd_pkg::ESC_BYTE, CHK_MODEL},
        '{efd_pkg::ESC_ESC, CHK_MODEL}, '{8'hFF, CHK_MODEL},
        '{efd_pkg::FLAG_BYTE, CHK_NONE}
    };

    localparam logic [7:0] TRICKY_BYTES [7] = '{
        efd_pkg::FLAG_BYTE, efd_pkg::ESC_BYTE, efd_pkg::ESC_FLAG, efd_pkg::ESC_ESC,
        efd_pkg::CTRL_MAX, 8'h21, 8'h00
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [efd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [efd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;    // rx_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // command[7:0], lead_word[39:8], length_code[47:40], payload[111:48]
    logic [efd_pkg::OUT_W-1:0]      m_axis_tdata;

    efd_pkg::t_cfg             hdr_cfg = '{efd_pkg::RST_HDR_ADDR, efd_pkg::RST_HDR_CTRL,
                                           efd_pkg::RST_PROTO_ID, efd_pkg::RST_LEN_FLD};
    logic                      in_frame_m = 1'b0;
    logic                      esc_m = 1'b0;
    logic [efd_pkg::IDX_W-1:0] idx_m = efd_pkg::IDX_FIRST;
    logic [7:0]                body_m [efd_pkg::BODY_LEN] = '{default: '0};

    t_frame   frames_q [$];
    t_rx_item rx_q [$];
    t_rx_item next_item;
    t_chk     drv_chk = CHK_MODEL;
    t_frame   frame_pred;
    bit       frame_due;
    bit       last_was_flag = 1'b1;

    int cycle_count = 0;
    int rx_cycles = 0;
    int hold_left = 0;
    int burst_left = 1;
    int gap_left = 0;
    int bytes_queued = 0;
    int bytes_in = 0;
    int frames_out = 0;
    int errors = 0;

    escaped_frame_deframer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void drop_frame();
        in_frame_m = 1'b0;
        esc_m      = 1'b0;
        idx_m      = efd_pkg::IDX_FIRST;
    endfunction

    function automatic void keep_body_byte(logic [7:0] b);
        if (idx_m < efd_pkg::IDX_DONE) begin
            body_m[idx_m - 1] = b;
            idx_m = idx_m + 1'b1;
        end else begin
            drop_frame();
        end
    endfunction

    function automatic bit close_frame(output t_frame f);
        logic [7:0] x;
        logic [7:0] s;
        x = '0;
        s = '0;
        f = '0;
        if (idx_m != efd_pkg::IDX_DONE) return 1'b0;
        if ({body_m[0], body_m[1], body_m[2], body_m[3], body_m[4], body_m[5]} !=
            {hdr_cfg.hdr_addr, hdr_cfg.hdr_ctrl, hdr_cfg.proto_id, hdr_cfg.len_fld})
            return 1'b0;
        for (int n = 0; n < 20; n++) begin
            x = x ^ body_m[n];
            s = s + body_m[n];
        end
        if (x != body_m[20] || s != body_m[21]) return 1'b0;
        f.command     = body_m[6];
        f.lead_word   = {body_m[7], body_m[8], body_m[9], body_m[10]};
        f.length_code = body_m[11];
        f.payload     = {body_m[12], body_m[13], body_m[14], body_m[15],
                         body_m[16], body_m[17], body_m[18], body_m[19]};
        return 1'b1;
    endfunction

    function automatic void deframe_byte(logic [7:0] b, output bit got, output t_frame f);
        got = 1'b0;
        f   = '0;
        if (b == efd_pkg::FLAG_BYTE) begin
            if (in_frame_m) got = close_frame(f);
            in_frame_m = 1'b1;
            esc_m      = 1'b0;
            idx_m      = efd_pkg::IDX_FIRST;
            body_m     = '{default: '0};
        end else if (!in_frame_m) begin
            esc_m = 1'b0;
            idx_m = efd_pkg::IDX_FIRST;
        end else if (b == efd_pkg::ESC_BYTE) begin
            esc_m = 1'b1;
        end else if (esc_m) begin
            esc_m = 1'b0;
            if (b <= efd_pkg::CTRL_MAX) keep_body_byte(b);
            else if (b == efd_pkg::ESC_FLAG) keep_body_byte(efd_pkg::FLAG_BYTE);
            else if (b == efd_pkg::ESC_ESC) keep_body_byte(efd_pkg::ESC_BYTE);
            else drop_frame();
        end else if (b > efd_pkg::CTRL_MAX) begin
            keep_body_byte(b);
        end else begin
            drop_frame();
        end
    endfunction

    function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic void check_frame(t_frame act);
        t_frame want;
        if (frames_q.size() == 0) begin
            $display("%0t: frame mismatch, expected none, actual %h", $time, act);
            errors++;
        end else begin
            want = frames_q.pop_front();
            frames_out++;
            cmp_field("command", want.command, act.command);
            cmp_field("lead_word", want.lead_word, act.lead_word);
            cmp_field("length_code", want.length_code, act.length_code);
            cmp_field("payload", want.payload, act.payload);
        end
    endfunction

    function automatic void push_rx(logic [7:0] b);
        rx_q.push_back('{b, CHK_MODEL});
        bytes_queued++;
        last_was_flag = (b == efd_pkg::FLAG_BYTE);
    endfunction

    function automatic void push_body(logic [7:0] b);
        if (b == efd_pkg::FLAG_BYTE || b == efd_pkg::ESC_BYTE || b <= efd_pkg::CTRL_MAX) begin
            push_rx(efd_pkg::ESC_BYTE);
            if ($urandom_range(0, 15) == 0) push_rx(efd_pkg::ESC_BYTE);
            push_rx(b == efd_pkg::FLAG_BYTE ? efd_pkg::ESC_FLAG :
                    b == efd_pkg::ESC_BYTE ? efd_pkg::ESC_ESC : b);
        end else begin
            push_rx(b);
        end
    endfunction

    // returns 1 when the frame is built to decode
    function automatic bit queue_frame();
        logic [7:0] body [efd_pkg::BODY_LEN + 1];
        logic [7:0] x;
        logic [7:0] s;
        logic [7:0] bad;
        int kind;
        int fill;
        int nbody;
        int spot;
        kind  = $urandom_range(0, 99);
        fill  = $urandom_range(0, 5);
        nbody = efd_pkg::BODY_LEN;
        spot  = $urandom_range(0, efd_pkg::BODY_LEN - 1);
        x = '0;
        s = '0;
        {body[0], body[1], body[2], body[3], body[4], body[5]} =
            {hdr_cfg.hdr_addr, hdr_cfg.hdr_ctrl, hdr_cfg.proto_id, hdr_cfg.len_fld};
        for (int n = 6; n <= efd_pkg::BODY_LEN; n++) begin
            case (fill)
                0: body[n] = 8'h00;
                1: body[n] = 8'hFF;
                2: body[n] = TRICKY_BYTES[$urandom_range(0, 6)];
                default: body[n] = 8'($urandom);
            endcase
        end
        for (int n = 0; n < 20; n++) begin
            x = x ^ body[n];
            s = s + body[n];
        end
        body[20] = x;
        body[21] = s;
        if (kind < 8) body[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
        else if (kind < 14) body[$urandom_range(20, 21)] ^= 8'(1 << $urandom_range(0, 7));
        else if (kind < 18) nbody = $urandom_range(0, efd_pkg::BODY_LEN - 1);
        else if (kind < 22) nbody = efd_pkg::BODY_LEN + 1;
        if (!last_was_flag || $urandom_range(0, 1) == 1) push_rx(efd_pkg::FLAG_BYTE);
        for (int n = 0; n < nbody; n++) begin
            if (n == spot && kind >= 22 && kind < 24) begin
                push_rx(8'($urandom_range(0, 32'(efd_pkg::CTRL_MAX))));
            end else if (n == spot && kind >= 24 && kind < 26) begin
                push_rx(efd_pkg::ESC_BYTE);
                do bad = 8'($urandom_range(32'(efd_pkg::CTRL_MAX) + 1, 255));
                while (bad == efd_pkg::ESC_FLAG || bad == efd_pkg::ESC_ESC ||
                       bad == efd_pkg::ESC_BYTE || bad == efd_pkg::FLAG_BYTE);
                push_rx(bad);
            end
            push_body(body[n]);
        end
        if (kind >= 26 && kind < 32) push_rx(efd_pkg::ESC_BYTE);
        push_rx(efd_pkg::FLAG_BYTE);
        return kind >= 26;
    endfunction

    function automatic void queue_noise();
        repeat ($urandom_range(1, 6)) push_rx(8'($urandom));
        last_was_flag = 1'b0;
    endfunction

    task automatic queue_random_traffic();
        int start_count;
        int built;
        start_count = bytes_queued;
        built = 0;
        while (bytes_queued - start_count < BYTES_PER_SETTING || built < FRAMES_PER_SETTING) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else if (queue_frame()) built++;
        end
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (rx_q.size() != 0 || s_axis_tvalid || frames_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setting(efd_pkg::t_cfg c);
        logic [efd_pkg::CFG_IDX_W-1:0]  regs [4];
        logic [efd_pkg::CFG_DATA_W-1:0] vals [4];
        regs = '{efd_pkg::CFG_HDR_ADDR, efd_pkg::CFG_HDR_CTRL,
                 efd_pkg::CFG_PROTO_ID, efd_pkg::CFG_LEN_FLD};
        vals = '{{8'($urandom), c.hdr_addr}, {8'($urandom), c.hdr_ctrl}, c.proto_id, c.len_fld};
        for (int k = 0; k < 4; k++) begin
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        hdr_cfg = c;
    endtask

    // sender: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (rx_q.size() != 0) begin
                next_item = rx_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.data;
                drv_chk       <= next_item.chk;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 8);
                    gap_left   <= ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus two long hold-offs
    always @(posedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_cycles == 300 || rx_cycles == 900) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            case (rx_cycles[8:6])
                3'd2: m_axis_tready <= 1'($urandom_range(0, 1));
                3'd3: m_axis_tready <= ($urandom_range(0, 3) == 0);
                3'd4: m_axis_tready <= ($urandom_range(0, 7) != 0);
                3'd6: m_axis_tready <= ($urandom_range(0, 31) != 0);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata, frame_due, frame_pred);
                bytes_in++;
                if (frame_due && drv_chk == CHK_MODEL) frames_q.push_back(frame_pred);
            end
            if (m_axis_tvalid && m_axis_tready) check_frame(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        efd_pkg::t_cfg setting;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED_ROWS[r]) rx_q.push_back(DIRECTED_ROWS[r]);
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            if (p != 0) begin
                wait_quiet();
                case (p)
                    1: setting = '0;
                    2: setting = '1;
                    3: setting = '{efd_pkg::FLAG_BYTE, efd_pkg::ESC_BYTE,
                                   {efd_pkg::FLAG_BYTE, efd_pkg::ESC_BYTE},
                                   {efd_pkg::CTRL_MAX, efd_pkg::FLAG_BYTE}};
                    default: begin
                        setting.hdr_addr = 8'($urandom);
                        setting.hdr_ctrl = 8'($urandom);
                        setting.proto_id = 16'($urandom);
                        setting.len_fld  = 16'($urandom);
                    end
                endcase
                load_setting(setting);
            end
            queue_random_traffic();
        end
        wait_quiet();
        $display("%0d bytes over %0d header settings, %0d frames decoded and checked",
                 bytes_in, NUM_SETTINGS, frames_out);
        $display("covered escapes, aborts, short and overlong frames, bad headers and sums");
        if (errors == 0 && frames_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
